FILE: rtl/least_sent_piece_picker_assert.svh
// Assertion macros shared by the least-sent piece picker.
`ifndef LEAST_SENT_PIECE_PICKER_ASSERT_SVH
`define LEAST_SENT_PIECE_PICKER_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define LSPP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Checks that an implication holds in the cycle after its antecedent.
`define LSPP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/lspp_pkg.sv
// Package with constants and types of the least-sent piece picker.
package lspp_pkg;
  localparam int BodyBlocks     = 256;
  localparam int ManifestBlocks = 16;
  localparam int BlockBytes     = 64;
  localparam int CountMax       = 255;
  localparam int CountW         = 8;
  localparam int TieW           = 9;

  typedef enum logic [1:0] {
    MODE_SEEN  = 2'd0,
    MODE_PICK  = 2'd1,
    MODE_SLIDE = 2'd2,
    MODE_RESET = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_MANIFEST_LENGTH = 1'b0,
    CFG_BODY_LENGTH     = 1'b1
  } cfg_index_t;
endpackage

FILE: rtl/lspp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lspp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/least_sent_piece_picker.sv
// Least-sent piece picker: block state in RAMs, one sequencer walks the entries.
// Tracks one peer's transfer: MANIFEST_BLOCKS manifest and BODY_BLOCKS body blocks,
// each with a received bit and a saturating sent count held in one RAM word per block
// (manifest entries first, then body). One transaction is handled at a time and
// s_tready is high only while the sequencer idles. A seen piece takes one setup step,
// then one read-modify-write per entry; a restart runs a clearing pass, and a slide
// copies the body received bits to a second RAM and reads them back shifted. A pick
// scans all entries for the least value and the tie count, reduces random_value modulo
// the tie count with a one-bit-per-cycle divider and scans again to locate the choice
// before its result stage; with no candidate it skips the division and the second scan.
// A pick also waits in its result stage while an earlier result has not been taken.
// After reset a clearing pass runs before the first item is taken.
`include "least_sent_piece_picker_assert.svh"
module least_sent_piece_picker #(
  parameter int BODY_BLOCKS     = lspp_pkg::BodyBlocks,
  parameter int MANIFEST_BLOCKS = lspp_pkg::ManifestBlocks,
  parameter int BLOCK_BYTES     = lspp_pkg::BlockBytes,
  parameter int COUNT_MAX       = lspp_pkg::CountMax
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], piece_in_man[2], piece_start[34:3], byte_count[50:35],
  // mark_received[51], window_offset[83:52], random_value[99:84], zeros above
  input  logic [103:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found[0], pick_in_man[1], send_offset[33:2], tie_count[42:34], zeros above
  output logic [47:0] m_tdata
);
  localparam int Total = MANIFEST_BLOCKS + BODY_BLOCKS;
  localparam int AW    = $clog2(Total);
  localparam int IW    = $clog2(Total + 1);
  localparam int BW    = $clog2(BODY_BLOCKS);
  localparam int BBits = $clog2(BLOCK_BYTES);
  localparam int CW    = lspp_pkg::CountW;
  localparam int VW    = CW + 1;
  localparam int TW    = lspp_pkg::TieW;
  localparam int EW    = CW + 1;
  localparam logic [VW-1:0] CntMax = VW'(COUNT_MAX);
  localparam logic [IW-1:0] ManN   = IW'(MANIFEST_BLOCKS);
  localparam logic [IW-1:0] TotN   = IW'(Total);
  localparam logic [BW:0]   BodyN  = (BW+1)'(BODY_BLOCKS);
  localparam logic [33:0]   WinB   = 34'(BODY_BLOCKS) * 34'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_SCAN1, ST_DIV, ST_SCAN2,
    ST_SLIDE1, ST_SLIDE2, ST_OUT
  } state_t;

  state_t state;

  logic [10:0] man_bytes;
  logic [31:0] body_length;
  logic [31:0] window_start, body_send_point;

  // Latched item.
  logic        it_man, it_mark;
  logic [31:0] it_start, it_woff;
  logic [15:0] it_bytes, it_rnd;

  // Entry RAM: {received, count}.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // Slide copy RAM: holds the old body received bits.
  logic          cp_we;
  logic [BW-1:0] cp_waddr, cp_raddr;
  logic          cp_wdata, cp_rdata;

  lspp_ram #(.Width(EW), .Depth(Total)) u_entries (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
  lspp_ram #(.Width(1), .Depth(BODY_BLOCKS)) u_copy (
    .clk, .we(cp_we), .waddr(cp_waddr), .wdata(cp_wdata),
    .raddr(cp_raddr), .rdata(cp_rdata)
  );

  // Walk index and the index of the entry whose data is on the RAM output.
  logic [IW-1:0] idx, ridx;
  logic          rvalid;
  logic [BW:0]   sidx, sridx;
  logic          svalid;

  // Body update range: blocks [blk_lo, blk_hi).
  logic [33:0] blk_lo_w, blk_hi_w;
  logic [33:0] blk_lo, blk_hi;
  logic        body_act;

  // Pick bookkeeping; pick_* and p_* hold a finished pick until the result stage.
  logic [VW-1:0] least;
  logic [TW+8:0] ties;
  logic [TW+8:0] sel, seen;
  logic [15:0]   rem_q;
  logic [16:0]   rem_r;
  logic [4:0]    div_n;
  logic          pick_man;
  logic [31:0]   pick_off;
  logic          p_found;
  logic [TW-1:0] p_tie;

  // Slide offset in blocks, signed.
  logic signed [34:0] delta;

  // Result register.
  logic        r_found, r_man;
  logic [31:0] r_off;
  logic [TW-1:0] r_tie;

  // During the second slide pass the copy RAM and entry RAM read together.
  logic slide_bit, slide_ok;

  // Body trim and block range computed from the latched item.
  logic [32:0] off_w, off_r;
  logic [16:0] rem_w;
  logic [BBits-1:0] mis;
  logic [32:0] endp;
  always_comb begin
    off_w = {1'b0, it_start} - {1'b0, window_start};
    mis   = off_w[BBits-1:0];
    endp  = {1'b0, it_start} + 33'(it_bytes);
    off_r = off_w;
    rem_w = {1'b0, it_bytes};
    if (mis != '0 && endp < {1'b0, body_length}) begin
      off_r = off_w + 33'(BLOCK_BYTES) - 33'(mis);
      rem_w = {1'b0, it_bytes} - 17'(mis);
    end
    blk_lo_w = 34'(off_r >> BBits);
    if (rem_w[16]) blk_hi_w = blk_lo_w;
    else           blk_hi_w = blk_lo_w + 34'(rem_w >> BBits);
  end

  // Per-entry attributes of the entry on the RAM output.
  logic          r_is_man;
  logic [IW-1:0] r_bidx;
  logic [33:0]   r_pos;
  logic [31:0]   r_moff;
  logic          r_cand;
  logic [VW-1:0] r_val;
  always_comb begin
    r_is_man = ridx < ManN;
    r_bidx   = ridx - ManN;
    r_moff   = 32'(ridx) << BBits;
    r_pos    = 34'(window_start) + (34'(r_bidx) << BBits);
    if (r_is_man) r_cand = (34'(r_moff) < 34'(man_bytes)) && !ram_rdata[CW];
    else          r_cand = (r_pos <= 34'(body_length)) && !ram_rdata[CW];
    r_val = {1'b0, ram_rdata[CW-1:0]} + VW'(ridx[0] ^ (r_is_man ? 1'b0 : ManN[0]));
  end

  // Whether the update pass touches the entry on the RAM output.
  logic          upd_hit;
  logic [33:0]   mpos;
  always_comb begin
    mpos = 34'(r_moff);
    if (it_man) begin
      upd_hit = r_is_man && (34'(it_start) <= mpos) &&
                (34'(it_start) + 34'(it_bytes) >= mpos);
    end else begin
      upd_hit = !r_is_man && body_act && (34'(r_bidx) >= blk_lo) &&
                (34'(r_bidx) < blk_hi);
    end
  end

  logic [CW-1:0] bumped;
  assign bumped = ({1'b0, ram_rdata[CW-1:0]} < CntMax) ? ram_rdata[CW-1:0] + 1'b1
                                                        : ram_rdata[CW-1:0];

  logic [33:0] end_sum;
  logic [31:0] end_sat;
  always_comb begin
    end_sum = 34'(window_start) + WinB;
    end_sat = (end_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : end_sum[31:0];
  end

  logic signed [34:0] old_b;
  assign old_b = $signed({1'b0, sidx}) + delta;

  logic signed [33:0] dsub;
  always_comb begin
    dsub = $signed({2'b0, it_woff}) - $signed({2'b0, window_start});
    // Truncating division toward zero by a power of two.
    if (dsub < 0) delta = -35'($signed(-dsub) >>> BBits);
    else          delta = 35'(dsub >>> BBits);
  end

  assign slide_bit = slide_ok && cp_rdata;

  // RAM port driving.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ridx[AW-1:0];
    ram_wdata = '0;
    ram_raddr = idx[AW-1:0];
    cp_we     = 1'b0;
    cp_waddr  = sridx[BW-1:0];
    cp_wdata  = ram_rdata[CW];
    cp_raddr  = sidx[BW-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
      end
      ST_UPD_WR: begin
        ram_we    = rvalid && upd_hit;
        ram_wdata = {ram_rdata[CW] | it_man | it_mark, bumped};
      end
      ST_SLIDE1: begin
        ram_raddr = AW'(sidx[BW-1:0]) + AW'(MANIFEST_BLOCKS);
        cp_we     = svalid;
      end
      ST_SLIDE2: begin
        ram_raddr = AW'(sidx[BW-1:0]) + AW'(MANIFEST_BLOCKS);
        ram_waddr = AW'(sridx[BW-1:0]) + AW'(MANIFEST_BLOCKS);
        cp_raddr  = BW'(old_b);
        ram_we    = svalid;
        ram_wdata = {slide_bit, ram_rdata[CW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      idx             <= '0;
      man_bytes       <= '0;
      body_length     <= '0;
      window_start    <= '0;
      body_send_point <= '0;
      m_tvalid        <= 1'b0;
      rvalid          <= 1'b0;
      svalid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lspp_pkg::CFG_MANIFEST_LENGTH) man_bytes <= cfg_data[10:0];
        else body_length <= cfg_data;
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      ridx   <= idx;
      sridx  <= sidx;
      unique case (state)
        ST_CLEAR: begin
          if (idx == TotN - 1'b1) begin
            state <= ST_IDLE;
          end
          idx <= idx + 1'b1;
        end
        ST_IDLE: begin
          rvalid <= 1'b0;
          svalid <= 1'b0;
          if (s_tvalid) begin
            it_man   <= s_tdata[2];
            it_start <= s_tdata[34:3];
            it_bytes <= s_tdata[50:35];
            it_mark  <= s_tdata[51];
            it_woff  <= s_tdata[83:52];
            it_rnd   <= s_tdata[99:84];
            idx      <= '0;
            sidx     <= '0;
            unique case (lspp_pkg::mode_t'(s_tdata[1:0]))
              lspp_pkg::MODE_SEEN:  state <= ST_UPD_RD;
              lspp_pkg::MODE_PICK: begin
                state <= ST_SCAN1;
                least <= CntMax;
                ties  <= '0;
              end
              lspp_pkg::MODE_SLIDE: state <= ST_SLIDE1;
              lspp_pkg::MODE_RESET: begin
                state        <= ST_CLEAR;
                window_start <= s_tdata[83:52];
              end
            endcase
          end
        end
        ST_UPD_RD: begin
          body_act <= !it_man && (it_start >= window_start);
          blk_lo   <= blk_lo_w;
          blk_hi   <= (blk_hi_w > 34'(BodyN)) ? 34'(BodyN) : blk_hi_w;
          state    <= ST_UPD_WR;
          idx      <= idx + 1'b1;
          rvalid   <= 1'b1;
        end
        ST_UPD_WR: begin
          // Each entry is read, then written back the next cycle; addresses never repeat.
          if (ridx == TotN - 1'b1) begin
            state  <= ST_IDLE;
            rvalid <= 1'b0;
          end
          if (idx != TotN) idx <= idx + 1'b1;
        end
        ST_SCAN1: begin
          if (idx != TotN) idx <= idx + 1'b1;
          rvalid <= (idx != TotN);
          if (rvalid && r_cand) begin
            if (r_val < least) begin
              least <= r_val;
              ties  <= 18'd1;
            end else if (r_val == least) begin
              ties <= ties + 1'b1;
            end
          end
          if (rvalid && ridx == TotN - 1'b1) begin
            rvalid <= 1'b0;
            rem_q  <= it_rnd;
            rem_r  <= '0;
            div_n  <= '0;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ties == '0) begin
            if (34'(body_send_point) <= 34'(end_sat)) body_send_point <= end_sat;
            p_found  <= 1'b0;
            pick_man <= 1'b0;
            pick_off <= (34'(body_send_point) <= 34'(end_sat)) ? end_sat : body_send_point;
            p_tie    <= '0;
            state    <= ST_OUT;
          end else if (div_n == 5'd16) begin
            sel   <= 18'(rem_r);
            seen  <= '0;
            idx   <= '0;
            state <= ST_SCAN2;
          end else begin
            // Restoring division, one quotient bit per cycle.
            if ({rem_r[15:0], rem_q[15]} >= 17'(ties)) begin
              rem_r <= {rem_r[15:0], rem_q[15]} - 17'(ties);
            end else begin
              rem_r <= {rem_r[15:0], rem_q[15]};
            end
            rem_q <= {rem_q[14:0], 1'b0};
            div_n <= div_n + 1'b1;
          end
        end
        ST_SCAN2: begin
          if (idx != TotN) idx <= idx + 1'b1;
          rvalid <= (idx != TotN);
          if (rvalid && r_cand && r_val == least) begin
            if (seen == sel) begin
              pick_man <= r_is_man;
              pick_off <= r_is_man ? r_moff : r_pos[31:0];
            end
            seen <= seen + 1'b1;
          end
          if (rvalid && ridx == TotN - 1'b1) begin
            rvalid  <= 1'b0;
            state   <= ST_OUT;
            p_found <= 1'b1;
            p_tie   <= ties[TW-1:0];
            if (r_cand && r_val == least && seen == sel) begin
              if (!r_is_man) body_send_point <= r_pos[31:0];
            end else begin
              if (!pick_man) body_send_point <= pick_off;
            end
          end
        end
        ST_SLIDE1: begin
          if (sidx != BodyN) sidx <= sidx + 1'b1;
          svalid <= (sidx != BodyN);
          if (svalid && sridx == BodyN - 1'b1) begin
            svalid <= 1'b0;
            sidx   <= '0;
            state  <= ST_SLIDE2;
          end
        end
        ST_SLIDE2: begin
          slide_ok <= (sidx != '0) && (old_b >= 0) && (old_b < $signed({1'b0, 34'(BodyN)}));
          if (sidx != BodyN) sidx <= sidx + 1'b1;
          svalid <= (sidx != BodyN);
          if (svalid && sridx == BodyN - 1'b1) begin
            svalid       <= 1'b0;
            window_start <= it_woff;
            state        <= ST_IDLE;
          end
        end
        ST_OUT: begin
          // The result register loads only when the previous result has gone.
          if (!m_tvalid || m_tready) begin
            r_found  <= p_found;
            r_man    <= pick_man;
            r_off    <= pick_off;
            r_tie    <= p_tie;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {5'b0, r_tie, r_off, r_man, r_found};

  `LSPP_ASSERT_IMP(a_busy_no_ready, clk, rst, state != ST_IDLE, !s_tready)
  `LSPP_ASSERT_NEXT(a_out_goes_idle, clk, rst, state == ST_OUT && !m_tvalid, state == ST_IDLE)
  `LSPP_ASSERT_IMP(a_notfound_zero, clk, rst, m_tvalid && !m_tdata[0],
                   m_tdata[42:34] == '0 && !m_tdata[1])
endmodule
